// ----- src/rthsv_pkg.sv -----
package rthsv_pkg;

   // default component width
   localparam int RTHSV_COMPONENT_BITS = 8;

   // result field widths
   localparam int HUE_BITS = 13;
   localparam int SAT_BITS = 9;

   // quotient bits resolved by the divider pipeline (hue quotient reaches 960)
   localparam int QUO_BITS = 10;

   // saturation is scaled by 256 before the divide
   localparam int SAT_SHIFT = 8;

   // sixty degrees and a full turn, in sixteenths of a degree
   localparam logic [HUE_BITS-1:0] HUE_SECTOR = 13'd960;
   localparam logic [HUE_BITS-1:0] HUE_FULL   = 13'd5760;

   // dominant component, red wins ties, then green
   typedef enum logic [1:0] {
      SECTOR_RED   = 2'd0,
      SECTOR_GREEN = 2'd1,
      SECTOR_BLUE  = 2'd2
   } rthsv_sector_type;

   // per-pixel control that rides along the divider pipeline
   typedef struct packed {
      rthsv_sector_type sector;
      logic             neg;    // hue difference term is negative
      logic             grey;   // max equals min
      logic             black;  // max is zero
   } rthsv_side_type;

endpackage

// ----- src/rthsv_req_if.sv -----
interface rthsv_req_if #(
   parameter int COMPONENT_BITS = rthsv_pkg::RTHSV_COMPONENT_BITS
);
   logic                      valid;
   logic                      ready;
   logic [COMPONENT_BITS-1:0] red;
   logic [COMPONENT_BITS-1:0] green;
   logic [COMPONENT_BITS-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- src/rthsv_rsp_if.sv -----
interface rthsv_rsp_if #(
   parameter int COMPONENT_BITS = rthsv_pkg::RTHSV_COMPONENT_BITS
);
   logic                              valid;
   logic                              ready;
   logic [rthsv_pkg::HUE_BITS-1:0]    hue;
   logic [rthsv_pkg::SAT_BITS-1:0]    saturation;
   logic [COMPONENT_BITS-1:0]         brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

// ----- src/rthsv_front.sv -----
module rthsv_front #(
   parameter int COMPONENT_BITS = rthsv_pkg::RTHSV_COMPONENT_BITS,
   parameter int NUM_BITS       = COMPONENT_BITS + rthsv_pkg::QUO_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [COMPONENT_BITS-1:0]   in_red,
   input  logic [COMPONENT_BITS-1:0]   in_green,
   input  logic [COMPONENT_BITS-1:0]   in_blue,
   output logic                        out_valid,
   output rthsv_pkg::rthsv_side_type   out_side,
   output logic [COMPONENT_BITS-1:0]   out_bright,
   output logic [NUM_BITS-1:0]         out_hue_num,
   output logic [COMPONENT_BITS-1:0]   out_hue_den,
   output logic [NUM_BITS-1:0]         out_sat_num,
   output logic [COMPONENT_BITS-1:0]   out_sat_den
);
   import rthsv_pkg::*;

   logic [COMPONENT_BITS-1:0] max_val;
   logic [COMPONENT_BITS-1:0] min_val;
   logic [COMPONENT_BITS-1:0] delta;
   logic [COMPONENT_BITS-1:0] sub_a;
   logic [COMPONENT_BITS-1:0] sub_b;
   logic [COMPONENT_BITS-1:0] diff_mag;
   rthsv_side_type            side_in;

   logic                      valid_ff;
   rthsv_side_type            side_ff;
   logic [COMPONENT_BITS-1:0] bright_ff;
   logic [NUM_BITS-1:0]       hue_num_ff;
   logic [COMPONENT_BITS-1:0] hue_den_ff;
   logic [NUM_BITS-1:0]       sat_num_ff;
   logic [COMPONENT_BITS-1:0] sat_den_ff;

   // extremes and dominant component
   always_comb begin
      max_val = in_red;
      if (in_green > max_val) max_val = in_green;
      if (in_blue > max_val)  max_val = in_blue;
      min_val = in_red;
      if (in_green < min_val) min_val = in_green;
      if (in_blue < min_val)  min_val = in_blue;
      delta = max_val - min_val;

      if (in_red == max_val) begin
         side_in.sector = SECTOR_RED;
         sub_a = in_green;
         sub_b = in_blue;
      end else if (in_green == max_val) begin
         side_in.sector = SECTOR_GREEN;
         sub_a = in_blue;
         sub_b = in_red;
      end else begin
         side_in.sector = SECTOR_BLUE;
         sub_a = in_red;
         sub_b = in_green;
      end

      // sign and magnitude of the difference term
      side_in.neg   = (sub_a < sub_b);
      diff_mag      = side_in.neg ? (sub_b - sub_a) : (sub_a - sub_b);
      side_in.grey  = (delta == '0);
      side_in.black = (max_val == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         side_ff    <= side_in;
         bright_ff  <= max_val;
         hue_num_ff <= NUM_BITS'(diff_mag) * NUM_BITS'(HUE_SECTOR);
         hue_den_ff <= delta;
         sat_num_ff <= NUM_BITS'(delta) << SAT_SHIFT;
         sat_den_ff <= max_val;
      end
   end

   assign out_valid   = valid_ff;
   assign out_side    = side_ff;
   assign out_bright  = bright_ff;
   assign out_hue_num = hue_num_ff;
   assign out_hue_den = hue_den_ff;
   assign out_sat_num = sat_num_ff;
   assign out_sat_den = sat_den_ff;

endmodule

// ----- src/rthsv_div_stage.sv -----
module rthsv_div_stage #(
   parameter int COMPONENT_BITS = rthsv_pkg::RTHSV_COMPONENT_BITS,
   parameter int NUM_BITS       = COMPONENT_BITS + rthsv_pkg::QUO_BITS,
   parameter int SHIFT          = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  rthsv_pkg::rthsv_side_type      in_side,
   input  logic [COMPONENT_BITS-1:0]      in_bright,
   input  logic [NUM_BITS-1:0]            in_hue_rem,
   input  logic [COMPONENT_BITS-1:0]      in_hue_den,
   input  logic [rthsv_pkg::QUO_BITS-1:0] in_hue_quo,
   input  logic [NUM_BITS-1:0]            in_sat_rem,
   input  logic [COMPONENT_BITS-1:0]      in_sat_den,
   input  logic [rthsv_pkg::QUO_BITS-1:0] in_sat_quo,
   output logic                           out_valid,
   output rthsv_pkg::rthsv_side_type      out_side,
   output logic [COMPONENT_BITS-1:0]      out_bright,
   output logic [NUM_BITS-1:0]            out_hue_rem,
   output logic [COMPONENT_BITS-1:0]      out_hue_den,
   output logic [rthsv_pkg::QUO_BITS-1:0] out_hue_quo,
   output logic [NUM_BITS-1:0]            out_sat_rem,
   output logic [COMPONENT_BITS-1:0]      out_sat_den,
   output logic [rthsv_pkg::QUO_BITS-1:0] out_sat_quo
);
   import rthsv_pkg::*;

   logic [NUM_BITS-1:0]       hue_den_sh;
   logic [NUM_BITS-1:0]       sat_den_sh;
   logic                      hue_ge;
   logic                      sat_ge;

   logic                      valid_ff;
   rthsv_side_type            side_ff;
   logic [COMPONENT_BITS-1:0] bright_ff;
   logic [NUM_BITS-1:0]       hue_rem_ff;
   logic [COMPONENT_BITS-1:0] hue_den_ff;
   logic [QUO_BITS-1:0]       hue_quo_ff;
   logic [NUM_BITS-1:0]       sat_rem_ff;
   logic [COMPONENT_BITS-1:0] sat_den_ff;
   logic [QUO_BITS-1:0]       sat_quo_ff;

   // one restoring step per lane: try subtracting the aligned divisor
   always_comb begin
      hue_den_sh = NUM_BITS'(in_hue_den) << SHIFT;
      sat_den_sh = NUM_BITS'(in_sat_den) << SHIFT;
      hue_ge     = (in_hue_rem >= hue_den_sh);
      sat_ge     = (in_sat_rem >= sat_den_sh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         side_ff    <= in_side;
         bright_ff  <= in_bright;
         hue_rem_ff <= hue_ge ? (in_hue_rem - hue_den_sh) : in_hue_rem;
         hue_den_ff <= in_hue_den;
         hue_quo_ff <= {in_hue_quo[QUO_BITS-2:0], hue_ge};
         sat_rem_ff <= sat_ge ? (in_sat_rem - sat_den_sh) : in_sat_rem;
         sat_den_ff <= in_sat_den;
         sat_quo_ff <= {in_sat_quo[QUO_BITS-2:0], sat_ge};
      end
   end

   assign out_valid   = valid_ff;
   assign out_side    = side_ff;
   assign out_bright  = bright_ff;
   assign out_hue_rem = hue_rem_ff;
   assign out_hue_den = hue_den_ff;
   assign out_hue_quo = hue_quo_ff;
   assign out_sat_rem = sat_rem_ff;
   assign out_sat_den = sat_den_ff;
   assign out_sat_quo = sat_quo_ff;

endmodule

// ----- src/rthsv_back.sv -----
module rthsv_back #(
   parameter int COMPONENT_BITS = rthsv_pkg::RTHSV_COMPONENT_BITS,
   parameter int NUM_BITS       = COMPONENT_BITS + rthsv_pkg::QUO_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           out_ready,
   output logic                           advance,
   input  logic                           in_valid,
   input  rthsv_pkg::rthsv_side_type      in_side,
   input  logic [COMPONENT_BITS-1:0]      in_bright,
   input  logic [NUM_BITS-1:0]            in_hue_rem,
   input  logic [rthsv_pkg::QUO_BITS-1:0] in_hue_quo,
   input  logic [rthsv_pkg::QUO_BITS-1:0] in_sat_quo,
   output logic                           out_valid,
   output logic [rthsv_pkg::HUE_BITS-1:0] out_hue,
   output logic [rthsv_pkg::SAT_BITS-1:0] out_saturation,
   output logic [COMPONENT_BITS-1:0]      out_brightness
);
   import rthsv_pkg::*;

   logic [HUE_BITS-1:0]       hue_step;
   logic [HUE_BITS-1:0]       hue_base;
   logic [HUE_BITS-1:0]       hue_in;
   logic [SAT_BITS-1:0]       sat_in;

   logic                      valid_ff;
   logic [HUE_BITS-1:0]       hue_ff;
   logic [SAT_BITS-1:0]       sat_ff;
   logic [COMPONENT_BITS-1:0] bright_ff;

   // whole pipeline moves unless a result sits unclaimed
   assign advance = !valid_ff || out_ready;

   // hue: sector base plus or minus the quotient, negative side rounds away
   always_comb begin
      hue_step = HUE_BITS'(in_hue_quo);
      if (in_side.neg && (in_hue_rem != '0)) hue_step = hue_step + HUE_BITS'(1);

      case (in_side.sector)
         SECTOR_RED:   hue_base = in_side.neg ? HUE_FULL : '0;
         SECTOR_GREEN: hue_base = HUE_SECTOR << 1;
         SECTOR_BLUE:  hue_base = HUE_SECTOR << 2;
         default:      hue_base = '0;
      endcase

      if (in_side.grey)     hue_in = '0;
      else if (in_side.neg) hue_in = hue_base - hue_step;
      else                  hue_in = hue_base + hue_step;

      sat_in = in_side.black ? '0 : in_sat_quo[SAT_BITS-1:0];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= in_bright;
      end
   end

   assign out_valid      = valid_ff;
   assign out_hue        = hue_ff;
   assign out_saturation = sat_ff;
   assign out_brightness = bright_ff;

endmodule

// ----- src/rgb_to_hsv_converter.sv -----
// Channel   Dir  Handshake     Beat contents
// req_bus   in   valid/ready   red, green, blue (COMPONENT_BITS each)
// rsp_bus   out  valid/ready   hue (13), saturation (9), brightness (COMPONENT_BITS)
//
// One beat in per clock and one beat out per clock while rsp_bus takes each result; the pipeline is
// a min/max stage, ten restoring divider stages that resolve
// one quotient bit each for hue and saturation side by side, and the output register.
// Synchronous reset clears only the valid bits. When a result waits on rsp_bus,
// every stage holds; req_bus.ready follows the output slot being free or taken.
module rgb_to_hsv_converter #(
   parameter int COMPONENT_BITS = rthsv_pkg::RTHSV_COMPONENT_BITS
) (
   input  logic         clock,
   input  logic         reset,
   rthsv_req_if.sink    req_bus,
   rthsv_rsp_if.source  rsp_bus
);
   import rthsv_pkg::*;

   localparam int NUM_BITS = COMPONENT_BITS + QUO_BITS;

   logic                      advance;

   // stage boundaries: index 0 is the front register, QUO_BITS the last divider step
   logic                      st_valid   [0:QUO_BITS];
   rthsv_side_type            st_side    [0:QUO_BITS];
   logic [COMPONENT_BITS-1:0] st_bright  [0:QUO_BITS];
   logic [NUM_BITS-1:0]       st_hue_rem [0:QUO_BITS];
   logic [COMPONENT_BITS-1:0] st_hue_den [0:QUO_BITS];
   logic [QUO_BITS-1:0]       st_hue_quo [0:QUO_BITS];
   logic [NUM_BITS-1:0]       st_sat_rem [0:QUO_BITS];
   logic [COMPONENT_BITS-1:0] st_sat_den [0:QUO_BITS];
   logic [QUO_BITS-1:0]       st_sat_quo [0:QUO_BITS];

   assign req_bus.ready = advance;

   // extremes, sector and divider operands
   rthsv_front #(
      .COMPONENT_BITS (COMPONENT_BITS),
      .NUM_BITS       (NUM_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_bus.valid),
      .in_red      (req_bus.red),
      .in_green    (req_bus.green),
      .in_blue     (req_bus.blue),
      .out_valid   (st_valid[0]),
      .out_side    (st_side[0]),
      .out_bright  (st_bright[0]),
      .out_hue_num (st_hue_rem[0]),
      .out_hue_den (st_hue_den[0]),
      .out_sat_num (st_sat_rem[0]),
      .out_sat_den (st_sat_den[0])
   );

   assign st_hue_quo[0] = '0;
   assign st_sat_quo[0] = '0;

   // divider pipeline, most significant quotient bit first
   for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
      rthsv_div_stage #(
         .COMPONENT_BITS (COMPONENT_BITS),
         .NUM_BITS       (NUM_BITS),
         .SHIFT          (QUO_BITS - 1 - k)
      ) u_stage (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .in_valid    (st_valid[k]),
         .in_side     (st_side[k]),
         .in_bright   (st_bright[k]),
         .in_hue_rem  (st_hue_rem[k]),
         .in_hue_den  (st_hue_den[k]),
         .in_hue_quo  (st_hue_quo[k]),
         .in_sat_rem  (st_sat_rem[k]),
         .in_sat_den  (st_sat_den[k]),
         .in_sat_quo  (st_sat_quo[k]),
         .out_valid   (st_valid[k+1]),
         .out_side    (st_side[k+1]),
         .out_bright  (st_bright[k+1]),
         .out_hue_rem (st_hue_rem[k+1]),
         .out_hue_den (st_hue_den[k+1]),
         .out_hue_quo (st_hue_quo[k+1]),
         .out_sat_rem (st_sat_rem[k+1]),
         .out_sat_den (st_sat_den[k+1]),
         .out_sat_quo (st_sat_quo[k+1])
      );
   end

   // hue assembly and output register
   rthsv_back #(
      .COMPONENT_BITS (COMPONENT_BITS),
      .NUM_BITS       (NUM_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .out_ready      (rsp_bus.ready),
      .advance        (advance),
      .in_valid       (st_valid[QUO_BITS]),
      .in_side        (st_side[QUO_BITS]),
      .in_bright      (st_bright[QUO_BITS]),
      .in_hue_rem     (st_hue_rem[QUO_BITS]),
      .in_hue_quo     (st_hue_quo[QUO_BITS]),
      .in_sat_quo     (st_sat_quo[QUO_BITS]),
      .out_valid      (rsp_bus.valid),
      .out_hue        (rsp_bus.hue),
      .out_saturation (rsp_bus.saturation),
      .out_brightness (rsp_bus.brightness)
   );

endmodule
